// ===== src/modular_exponentiation_assert.svh =====
// Assertion macros used by the modular exponentiation controller.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef MODULAR_EXPONENTIATION_ASSERT_SVH
`define MODULAR_EXPONENTIATION_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MODEXP_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MODEXP_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/modexp_pkg.sv =====
// ----------------------------------------------------------------------------
// modexp_pkg
// Shared constants and controller/datapath command and status types for the
// modular exponentiation block.
// ----------------------------------------------------------------------------
package modexp_pkg;

    localparam int EXP_BITS_DEF = 32;
    localparam int MOD_BITS_DEF = 31;

    localparam int BASE_W     = 31;
    localparam int EXP_W      = 32;
    localparam int POWER_W    = 31;
    localparam int MODULUS_W  = 31;
    localparam int APB_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;

    localparam logic [MODULUS_W-1:0] MODULUS_RESET = 31'd1000000007;

    // Register index taken from the word address.
    localparam logic [CFG_ADDR_W-3:0] REG_MODULUS = 1'b0;

    typedef struct packed {
        logic load;       // capture a new transaction, start base reduction
        logic step;       // advance both modular multipliers by one bit
        logic sq_load;    // square register takes the square unit result
        logic acc_load;   // result register takes the multiply unit result
        logic exp_shift;  // move to the next exponent bit
        logic mul_start;  // start both multipliers for the next exponent bit
        logic out_load;   // output register takes the finished result
    } dp_cmd_t;

    typedef struct packed {
        logic mod_small;  // modulus is zero or one
        logic exp_lsb;    // current exponent bit
    } dp_stat_t;

endpackage

// ===== src/modexp_req_if.sv =====
// ----------------------------------------------------------------------------
// modexp_req_if
// Request channel: base and exponent with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface modexp_req_if;

    logic                          valid;
    logic                          ready;
    logic [modexp_pkg::BASE_W-1:0] base;
    logic [modexp_pkg::EXP_W-1:0]  exponent;

    modport source (output valid, output base, output exponent, input ready);
    modport sink (input valid, input base, input exponent, output ready);

endinterface

// ===== src/modexp_rsp_if.sv =====
// ----------------------------------------------------------------------------
// modexp_rsp_if
// Response channel: power with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface modexp_rsp_if;

    logic                           valid;
    logic                           ready;
    logic [modexp_pkg::POWER_W-1:0] power;

    modport source (output valid, output power, input ready);
    modport sink (input valid, input power, output ready);

endinterface

// ===== src/modexp_mulmod.sv =====
// ----------------------------------------------------------------------------
// modexp_mulmod
// Interleaved modular multiplier: scans the multiplier MSB first, one bit per
// step, keeping the partial result below the modulus.
// ----------------------------------------------------------------------------
module modexp_mulmod #(
    parameter int MOD_BITS = modexp_pkg::MOD_BITS_DEF,
    parameter int B_W      = modexp_pkg::BASE_W
) (
    input  logic                clk,
    input  logic                start,
    input  logic                step,
    input  logic [MOD_BITS-1:0] modulus,
    input  logic [MOD_BITS-1:0] a,
    input  logic [B_W-1:0]      b,
    output logic [MOD_BITS-1:0] product
);

    localparam int T_W = MOD_BITS + 3;

    logic [MOD_BITS-1:0] a_reg;
    logic [MOD_BITS-1:0] a_next;
    logic [B_W-1:0]      b_reg;
    logic [B_W-1:0]      b_next;
    logic [MOD_BITS-1:0] r_reg;
    logic [MOD_BITS-1:0] r_next;

    logic [T_W-1:0] t;
    logic [T_W-1:0] d1;
    logic [T_W-1:0] d2;

    // Partial result stays below the modulus, so t = 2r + a stays below three
    // times the modulus and at most two subtractions are needed.
    always_comb
    begin
        t  = (T_W'(r_reg) << 1) + (b_reg[B_W-1] ? T_W'(a_reg) : T_W'(0));
        d1 = t - T_W'(modulus);
        d2 = t - (T_W'(modulus) << 1);
    end

    always_comb
    begin
        a_next = a_reg;
        b_next = b_reg;
        r_next = r_reg;
        if (start)
        begin
            a_next = a;
            b_next = b;
            r_next = '0;
        end
        else if (step)
        begin
            b_next = b_reg << 1;
            if (!d2[T_W-1])
            begin
                r_next = d2[MOD_BITS-1:0];
            end
            else if (!d1[T_W-1])
            begin
                r_next = d1[MOD_BITS-1:0];
            end
            else
            begin
                r_next = t[MOD_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        r_reg <= r_next;
    end

    assign product = r_reg;

endmodule

// ===== src/modexp_dp.sv =====
// ----------------------------------------------------------------------------
// modexp_dp
// Datapath: exponent shifter, square and result registers, two modular
// multipliers working side by side, and the output register.
// ----------------------------------------------------------------------------
module modexp_dp #(
    parameter int MOD_BITS = modexp_pkg::MOD_BITS_DEF
) (
    input  logic                           clk,
    input  modexp_pkg::dp_cmd_t            cmd,
    output modexp_pkg::dp_stat_t           stat,
    input  logic [MOD_BITS-1:0]            modulus,
    input  logic [modexp_pkg::BASE_W-1:0]  base,
    input  logic [modexp_pkg::EXP_W-1:0]   exponent,
    output logic [modexp_pkg::POWER_W-1:0] power
);

    localparam int B_W   = modexp_pkg::BASE_W;
    localparam int ALIGN = B_W - MOD_BITS;

    logic [modexp_pkg::EXP_W-1:0]   exp_reg;
    logic [modexp_pkg::EXP_W-1:0]   exp_next;
    logic [MOD_BITS-1:0]            sq_reg;
    logic [MOD_BITS-1:0]            sq_next;
    logic [MOD_BITS-1:0]            acc_reg;
    logic [MOD_BITS-1:0]            acc_next;
    logic [modexp_pkg::POWER_W-1:0] power_reg;
    logic [modexp_pkg::POWER_W-1:0] power_next;

    logic                mod_small;
    logic [MOD_BITS-1:0] prod_sq;
    logic [MOD_BITS-1:0] prod_acc;
    logic [MOD_BITS-1:0] sq_a;
    logic [B_W-1:0]      sq_b;
    logic [B_W-1:0]      sq_aligned;
    logic                sq_start;

    assign mod_small = (modulus < MOD_BITS'(2));

    always_comb
    begin
        sq_next  = cmd.sq_load ? prod_sq : sq_reg;
        acc_next = cmd.acc_load ? prod_acc : acc_reg;
        if (cmd.load)
        begin
            acc_next = mod_small ? '0 : MOD_BITS'(1);
        end
        exp_next = exp_reg;
        if (cmd.load)
        begin
            exp_next = exponent;
        end
        else if (cmd.exp_shift)
        begin
            exp_next = exp_reg >> 1;
        end
        power_next = cmd.out_load ? modexp_pkg::POWER_W'(acc_reg) : power_reg;
    end

    // Multiplier operands sit at the top of the scan register.
    assign sq_aligned = B_W'(sq_next) << ALIGN;

    // The square unit first reduces the base as 1 * base mod m.
    assign sq_start = cmd.load | cmd.mul_start;
    assign sq_a     = cmd.load ? MOD_BITS'(1) : sq_next;
    assign sq_b     = cmd.load ? base : sq_aligned;

    modexp_mulmod #(
        .MOD_BITS (MOD_BITS),
        .B_W      (B_W)
    ) u_mul_sq (
        .clk     (clk),
        .start   (sq_start),
        .step    (cmd.step),
        .modulus (modulus),
        .a       (sq_a),
        .b       (sq_b),
        .product (prod_sq)
    );

    modexp_mulmod #(
        .MOD_BITS (MOD_BITS),
        .B_W      (B_W)
    ) u_mul_acc (
        .clk     (clk),
        .start   (cmd.mul_start),
        .step    (cmd.step),
        .modulus (modulus),
        .a       (acc_next),
        .b       (sq_aligned),
        .product (prod_acc)
    );

    always_ff @(posedge clk)
    begin
        exp_reg   <= exp_next;
        sq_reg    <= sq_next;
        acc_reg   <= acc_next;
        power_reg <= power_next;
    end

    assign stat.mod_small = mod_small;
    assign stat.exp_lsb   = exp_reg[0];
    assign power          = power_reg;

endmodule

// ===== src/modexp_ctrl.sv =====
// ----------------------------------------------------------------------------
// modexp_ctrl
// Controller: sequences base reduction, one square-and-multiply round per
// exponent bit, and the hand-off of the result to the output register.
// ----------------------------------------------------------------------------
`include "modular_exponentiation_assert.svh"

module modexp_ctrl #(
    parameter int EXP_BITS = modexp_pkg::EXP_BITS_DEF,
    parameter int MOD_BITS = modexp_pkg::MOD_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    input  modexp_pkg::dp_stat_t stat,
    output modexp_pkg::dp_cmd_t  cmd
);

    localparam int STEP_W = $clog2(modexp_pkg::BASE_W);
    localparam int BIT_W  = $clog2(EXP_BITS + 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_REDUCE = 3'd1;
    localparam logic [2:0] ST_LOADSQ = 3'd2;
    localparam logic [2:0] ST_MUL    = 3'd3;
    localparam logic [2:0] ST_COMMIT = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    localparam logic [STEP_W-1:0] REDUCE_LAST = STEP_W'(modexp_pkg::BASE_W - 1);
    localparam logic [STEP_W-1:0] MUL_LAST    = STEP_W'(MOD_BITS - 1);
    localparam logic [BIT_W-1:0]  BIT_LAST    = BIT_W'(EXP_BITS - 1);

    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic [STEP_W-1:0] step_cnt_reg;
    logic [STEP_W-1:0] step_cnt_next;
    logic [BIT_W-1:0]  bit_cnt_reg;
    logic [BIT_W-1:0]  bit_cnt_next;
    logic              out_valid_reg;
    logic              out_valid_next;

    always_comb
    begin
        state_next    = state_reg;
        step_cnt_next = step_cnt_reg;
        bit_cnt_next  = bit_cnt_reg;
        cmd           = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load      = 1'b1;
                    step_cnt_next = '0;
                    bit_cnt_next  = '0;
                    state_next    = stat.mod_small ? ST_DONE : ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                cmd.step = 1'b1;
                if (step_cnt_reg == REDUCE_LAST)
                begin
                    state_next = ST_LOADSQ;
                end
                else
                begin
                    step_cnt_next = step_cnt_reg + STEP_W'(1);
                end
            end
            ST_LOADSQ:
            begin
                cmd.sq_load   = 1'b1;
                cmd.mul_start = 1'b1;
                step_cnt_next = '0;
                state_next    = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.step = 1'b1;
                if (step_cnt_reg == MUL_LAST)
                begin
                    state_next = ST_COMMIT;
                end
                else
                begin
                    step_cnt_next = step_cnt_reg + STEP_W'(1);
                end
            end
            ST_COMMIT:
            begin
                cmd.sq_load   = 1'b1;
                cmd.acc_load  = stat.exp_lsb;
                cmd.exp_shift = 1'b1;
                if (bit_cnt_reg == BIT_LAST)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    // The next round starts straight from the fresh products.
                    cmd.mul_start = 1'b1;
                    bit_cnt_next  = bit_cnt_reg + BIT_W'(1);
                    step_cnt_next = '0;
                    state_next    = ST_MUL;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_cnt_reg  <= '0;
            bit_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_cnt_reg  <= step_cnt_next;
            bit_cnt_reg   <= bit_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = out_valid_reg;

    `MODEXP_ASSERT_NEXT(a_accept_starts, req_valid && (state_reg == ST_IDLE), (state_reg == ST_REDUCE) || (state_reg == ST_DONE), "accepted transaction did not start")
    `MODEXP_ASSERT_NEXT(a_result_held, (state_reg == ST_DONE) && out_valid_reg && !rsp_ready, (state_reg == ST_DONE) && out_valid_reg, "finished result overwrote a waiting one")
    `MODEXP_ASSERT_SAME(a_step_range, (state_reg == ST_REDUCE) || (state_reg == ST_MUL), step_cnt_reg <= REDUCE_LAST, "step counter overran")
    `MODEXP_ASSERT_SAME(a_bit_range, (state_reg == ST_MUL) || (state_reg == ST_COMMIT), bit_cnt_reg <= BIT_LAST, "exponent bit counter overran")

endmodule

// ===== src/modular_exponentiation.sv =====
// ----------------------------------------------------------------------------
// modular_exponentiation
// Computes base ** exponent mod modulus by right-to-left square-and-multiply.
// ----------------------------------------------------------------------------
// One transaction at a time. After a request is accepted the base is reduced
// modulo the modulus one bit per cycle, then each of the EXP_BITS exponent
// bits takes one round, in which two interleaved bit-serial modular
// multipliers square the running square and multiply it into the result side
// by side. A modulus of zero or one gives a power of 0. The next request is
// accepted as soon as the result is in the output register, even while it
// waits to be taken. The modulus register (byte address 0, reset 1000000007)
// is to be written over the APB port only while the block is idle; the block
// itself does not enforce this. Only its low MOD_BITS bits are used.
// ----------------------------------------------------------------------------
module modular_exponentiation #(
    parameter int EXP_BITS = modexp_pkg::EXP_BITS_DEF,
    parameter int MOD_BITS = modexp_pkg::MOD_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    modexp_req_if.sink                        req,
    modexp_rsp_if.source                      rsp,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [modexp_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [modexp_pkg::APB_DATA_W-1:0] pwdata,
    output logic [modexp_pkg::APB_DATA_W-1:0] prdata,
    output logic                              pready
);

    localparam int MODULUS_W = modexp_pkg::MODULUS_W;

    logic [MODULUS_W-1:0] modulus_reg;
    logic [MODULUS_W-1:0] modulus_next;
    logic                 cfg_write;
    logic                 sel_modulus;

    modexp_pkg::dp_cmd_t  cmd;
    modexp_pkg::dp_stat_t stat;

    assign pready      = 1'b1;
    assign sel_modulus = (paddr[modexp_pkg::CFG_ADDR_W-1:2] == modexp_pkg::REG_MODULUS);
    assign cfg_write   = psel && penable && pwrite && pready;

    always_comb
    begin
        modulus_next = modulus_reg;
        if (cfg_write && sel_modulus)
        begin
            modulus_next = pwdata[MODULUS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= modexp_pkg::MODULUS_RESET;
        end
        else
        begin
            modulus_reg <= modulus_next;
        end
    end

    assign prdata = sel_modulus ? modexp_pkg::APB_DATA_W'(modulus_reg) : '0;

    modexp_ctrl #(
        .EXP_BITS (EXP_BITS),
        .MOD_BITS (MOD_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    modexp_dp #(
        .MOD_BITS (MOD_BITS)
    ) u_dp (
        .clk      (clk),
        .cmd      (cmd),
        .stat     (stat),
        .modulus  (modulus_reg[MOD_BITS-1:0]),
        .base     (req.base),
        .exponent (req.exponent),
        .power    (rsp.power)
    );

endmodule
